// ===== rtl/grid_min_climb_cost_dp_defines.svh =====
// Assertion macros shared by the grid minimum climb cost RTL.
`ifndef GRID_MIN_CLIMB_COST_DP_DEFINES_SVH
`define GRID_MIN_CLIMB_COST_DP_DEFINES_SVH

// Checked only outside reset.
`define GMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gmc_pkg.sv =====
// Shared constants, types and codes of the grid minimum climb cost block.
package gmc_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int ROW_LIMIT = 1024;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(ROW_LIMIT);
  localparam int HEIGHT_W  = 16;
  localparam int COST_W    = 32;
  localparam int DIM_W     = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FROM_ORIGIN = 2'd0,
    FROM_ABOVE  = 2'd1,
    FROM_LEFT   = 2'd2
  } from_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIMB = 2'd0,
    REG_ROWS  = 2'd1,
    REG_COLS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [COST_W-1:0]   cost;
  } cell_t;

  typedef struct packed {
    logic             first_row;
    logic             first_col;
    logic             last;
    logic [COL_W-1:0] col;
  } pos_t;

endpackage

// ===== rtl/gmc_row_store.sv =====
// Row store: heights and costs of the previous row, one entry per column.
module gmc_row_store
  import gmc_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  cell_t            wr_data,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output cell_t            rd_data
);

  cell_t mem [MAX_COLS];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // With a single column the next row reads the entry being written now.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/gmc_cell.sv =====
// Per-cell cost update: step costs from both neighbors, saturating sums, choice.
module gmc_cell
  import gmc_pkg::*;
(
  input  logic [HEIGHT_W-1:0] height,
  input  pos_t                pos,
  input  cell_t               above,
  input  cell_t               left,
  input  logic [HEIGHT_W-1:0] climb,
  output logic [COST_W-1:0]   cost,
  output from_t               came_from
);

  function automatic logic [HEIGHT_W-1:0] step_cost(
    input logic [HEIGHT_W-1:0] a,
    input logic [HEIGHT_W-1:0] b,
    input logic [HEIGHT_W-1:0] thr
  );
    logic [HEIGHT_W-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return (diff <= thr) ? '0 : (diff - thr);
  endfunction

  function automatic logic [COST_W-1:0] sat_add(
    input logic [COST_W-1:0]   a,
    input logic [HEIGHT_W-1:0] b
  );
    logic [COST_W:0] s;
    s = {1'b0, a} + (COST_W+1)'(b);
    return s[COST_W] ? '1 : s[COST_W-1:0];
  endfunction

  logic [COST_W-1:0] up_cost;
  logic [COST_W-1:0] lf_cost;

  assign up_cost = sat_add(above.cost, step_cost(above.height, height, climb));
  assign lf_cost = sat_add(left.cost, step_cost(left.height, height, climb));

  always_comb begin
    priority if (pos.first_row && pos.first_col) begin
      cost      = '0;
      came_from = FROM_ORIGIN;
    end else if (pos.first_row) begin
      cost      = lf_cost;
      came_from = FROM_LEFT;
    end else if (pos.first_col) begin
      cost      = up_cost;
      came_from = FROM_ABOVE;
    end else if (up_cost <= lf_cost) begin
      cost      = up_cost;
      came_from = FROM_ABOVE;
    end else begin
      cost      = lf_cost;
      came_from = FROM_LEFT;
    end
  end

endmodule

// ===== rtl/grid_min_climb_cost_dp.sv =====
// Top level of the grid minimum climb cost block: position counters and pipeline.
//
// Heights of a grid_rows by grid_cols grid enter on the in_ channel in
// row-major order, one beat per cell. For every cell one beat leaves on the
// out_ channel with the least accumulated climb cost from the top-left cell,
// the chosen predecessor and a flag on the bottom-right cell; the beat after
// that flag starts a new grid.
// An input beat passes through the input register, which also holds the
// registered read of the row store, then the result register. Barring
// stalls, throughput is one cell per cycle, set by the single read port
// and single write port of the row store and the left-neighbor registers.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more beat before in_ready drops.
// Reset (rst_n low at a clock edge) empties both registers, clears the grid
// position and sets the threshold to 0 and the grid to one by one. The row
// store is not cleared; a cost read from it is used only once written.
// Writing grid_rows or grid_cols restarts at the top-left cell; write the
// registers only while no beat is in flight.
module grid_min_climb_cost_dp
  import gmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [HEIGHT_W-1:0]  in_height,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COST_W-1:0]    out_min_cost,
  output logic [1:0]           out_came_from,
  output logic                 out_last_cell,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

`include "grid_min_climb_cost_dp_defines.svh"

  logic [HEIGHT_W-1:0] climb_r;
  logic [DIM_W-1:0]    rows_r;
  logic [DIM_W-1:0]    cols_r;
  logic [DIM_W-1:0]    rows_eff;
  logic [DIM_W-1:0]    cols_eff;

  logic [ROW_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic                row_end;
  logic                col_end;
  logic                size_write;

  logic                s1_valid_r;
  logic [HEIGHT_W-1:0] s1_height_r;
  pos_t                s1_pos_r;
  logic                in_fire;
  logic                s1_fire;

  cell_t               above;
  cell_t               left_r;
  cell_t               cell_new;
  logic [COST_W-1:0]   cell_cost;
  from_t               cell_from;

  logic                out_valid_r;
  logic [COST_W-1:0]   out_cost_r;
  from_t               out_from_r;
  logic                out_last_r;

  // Out-of-range sizes clamp: zero acts as one, oversize as the limit.
  assign rows_eff = (rows_r == '0) ? DIM_W'(1) :
                    (rows_r > DIM_W'(ROW_LIMIT)) ? DIM_W'(ROW_LIMIT) : rows_r;
  assign cols_eff = (cols_r == '0) ? DIM_W'(1) :
                    (cols_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_r;

  assign row_end = (DIM_W'(row_cnt_r) == rows_eff - DIM_W'(1));
  assign col_end = (DIM_W'(col_cnt_r) == cols_eff - DIM_W'(1));

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // A write to either size register restarts the grid at the top-left cell.
  assign size_write = cfg_we && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));

  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    if (size_write) begin
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
    end else if (in_fire) begin
      if (col_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_end ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      climb_r   <= '0;
      rows_r    <= DIM_W'(1);
      cols_r    <= DIM_W'(1);
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CLIMB: climb_r <= cfg_wdata;
          REG_ROWS:  rows_r  <= cfg_wdata[DIM_W-1:0];
          REG_COLS:  cols_r  <= cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Input register: height and grid position of the cell being worked on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_height_r        <= in_height;
      s1_pos_r.first_row <= (row_cnt_r == '0);
      s1_pos_r.first_col <= (col_cnt_r == '0);
      s1_pos_r.last      <= row_end && col_end;
      s1_pos_r.col       <= col_cnt_r;
    end
  end

  gmc_row_store u_row_store (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_pos_r.col),
    .wr_data (cell_new),
    .rd_en   (in_fire),
    .rd_addr (col_cnt_r),
    .rd_data (above)
  );

  gmc_cell u_cell (
    .height    (s1_height_r),
    .pos       (s1_pos_r),
    .above     (above),
    .left      (left_r),
    .climb     (climb_r),
    .cost      (cell_cost),
    .came_from (cell_from)
  );

  assign cell_new.height = s1_height_r;
  assign cell_new.cost   = cell_cost;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1_fire) begin
      left_r <= cell_new;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_cost_r <= cell_cost;
      out_from_r <= cell_from;
      out_last_r <= s1_pos_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_cost  = out_cost_r;
  assign out_came_from = out_from_r;
  assign out_last_cell = out_last_r;

  `GMC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid && !s1_valid_r, "pipeline not empty after reset")
  `GMC_ASSERT(a_col_in_range, DIM_W'(col_cnt_r) < cols_eff, "column counter beyond grid width")
  `GMC_ASSERT(a_origin_zero, out_valid && out_came_from == FROM_ORIGIN |-> out_min_cost == '0, "origin cell with nonzero cost")
  `GMC_ASSERT(a_wrap_after_last, in_fire && row_end && col_end && !cfg_we |=> row_cnt_r == '0 && col_cnt_r == '0, "grid did not restart after the last cell")
  `GMC_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_min_cost), "stalled result changed")

endmodule
